// File: rtl/sound_onset_detector_defines.svh
// Assertion macros used by the sound onset detector back end.
`ifndef SOUND_ONSET_DETECTOR_DEFINES_SVH
`define SOUND_ONSET_DETECTOR_DEFINES_SVH

// Same-cycle implication, checked on every clock edge outside reset.
`define SOD_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("sound_onset_detector: assertion failed");

// Next-cycle implication, checked on every clock edge outside reset.
`define SOD_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("sound_onset_detector: assertion failed");

`endif

// File: rtl/sod_pkg.sv
// Shared types, constants and register codes of the sound onset detector.
package sod_pkg;

  // Longest chunk that is evaluated; later samples of a chunk are ignored.
  localparam int MAX_CHUNK_SAMPLES = 4096;

  // Sample tally saturates at one past the limit to mark an over-long chunk.
  localparam int TALLY_W = $clog2(MAX_CHUNK_SAMPLES + 2);
  localparam int COUNT_W = $clog2(MAX_CHUNK_SAMPLES + 1);
  localparam int TOTAL_W = $clog2(longint'(MAX_CHUNK_SAMPLES) * 32768 + 1);
  localparam int STEP_W  = $clog2(TOTAL_W);

  // Register reset values.
  localparam logic [15:0] MIN_PEAK_RST   = 16'd12000;
  localparam logic [15:0] MIN_MEAN_RST   = 16'd1800;
  localparam logic [15:0] MEAN_RATIO_RST = 16'd350;
  localparam logic [15:0] PEAK_RATIO_RST = 16'd700;
  localparam logic [3:0]  FLOOR_SHIFT_RST = 4'd4;
  localparam logic [15:0] HOLDOFF_RST    = 16'd500;
  localparam logic [15:0] SETTLE_RST     = 16'd100;

  // Ratios are given in hundredths.
  localparam logic [15:0] RATIO_SCALE = 16'd100;

  typedef enum logic [2:0] {
    REG_MIN_PEAK    = 3'd0,
    REG_MIN_MEAN    = 3'd1,
    REG_MEAN_RATIO  = 3'd2,
    REG_PEAK_RATIO  = 3'd3,
    REG_FLOOR_SHIFT = 3'd4,
    REG_HOLDOFF     = 3'd5,
    REG_SETTLE      = 3'd6
  } reg_idx_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_DIV,
    BK_UPDATE,
    BK_MULT,
    BK_DECIDE
  } back_state_t;

  typedef struct packed {
    logic signed [15:0] sample;
    logic               last;
  } item_t;

  typedef struct packed {
    logic        event_res;
    logic [15:0] peak_level;
    logic [15:0] mean_level;
    logic [15:0] floor_level;
    logic        overlong;
  } result_t;

  // One closed chunk handed from the front to the back.
  typedef struct packed {
    logic [TOTAL_W-1:0] total;
    logic [COUNT_W-1:0] count;
    logic [15:0]        peak;
    logic               overlong;
  } chunk_t;

  typedef struct packed {
    logic [15:0] min_peak;
    logic [15:0] min_mean;
    logic [15:0] mean_ratio_x100;
    logic [15:0] peak_ratio_x100;
    logic [3:0]  floor_shift;
    logic [15:0] holdoff_chunks;
    logic [15:0] settle_chunks;
  } cfg_t;

endpackage

// File: rtl/sod_front.sv
// Front end: accumulates peak and magnitude sum of each chunk of samples.
module sod_front (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  sod_pkg::item_t  item,
  input  logic            cq_full,
  output logic            full,
  output logic            cq_push,
  output sod_pkg::chunk_t cq_wr
);
  import sod_pkg::*;

  logic [TALLY_W-1:0] tally;
  logic [TOTAL_W-1:0] total;
  logic [15:0]        peak;

  logic [TALLY_W-1:0] tally_next;
  logic [TOTAL_W-1:0] total_next;
  logic [15:0]        peak_next;
  logic [15:0]        raw;
  logic [15:0]        mag;
  logic               room;
  logic               accept;
  logic               long_chunk;

  assign full   = cq_full;
  assign accept = push && !cq_full;

  // Magnitude of the sample; the most negative value maps to 32768.
  always_comb begin
    raw = item.sample;
    mag = raw[15] ? (~raw + 16'd1) : raw;
  end

  // Accumulate only the first MAX_CHUNK_SAMPLES samples of a chunk.
  always_comb begin
    room       = tally < TALLY_W'(MAX_CHUNK_SAMPLES);
    tally_next = room ? tally + TALLY_W'(1) : TALLY_W'(MAX_CHUNK_SAMPLES + 1);
    total_next = room ? total + TOTAL_W'(mag) : total;
    peak_next  = (room && mag > peak) ? mag : peak;
    long_chunk = tally_next > TALLY_W'(MAX_CHUNK_SAMPLES);
  end

  // Closed chunk record for the back end.
  always_comb begin
    cq_push        = accept && item.last;
    cq_wr.total    = total_next;
    cq_wr.count    = long_chunk ? COUNT_W'(MAX_CHUNK_SAMPLES) : tally_next[COUNT_W-1:0];
    cq_wr.peak     = peak_next;
    cq_wr.overlong = long_chunk;
  end

  // Accumulator registers restart at every chunk end.
  always_ff @(posedge clk) begin
    if (rst) begin
      tally <= '0;
      total <= '0;
      peak  <= '0;
    end else if (accept) begin
      if (item.last) begin
        tally <= '0;
        total <= '0;
        peak  <= '0;
      end else begin
        tally <= tally_next;
        total <= total_next;
        peak  <= peak_next;
      end
    end
  end

endmodule

// File: rtl/sod_chunk_q.sv
// Two-entry queue of closed chunks between the front and the back end.
module sod_chunk_q (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  sod_pkg::chunk_t wr,
  input  logic            pop,
  output sod_pkg::chunk_t rd,
  output logic            empty,
  output logic            full
);
  import sod_pkg::*;

  chunk_t     slots [2];
  logic [1:0] cnt;
  logic [1:0] cnt_left;

  assign empty    = cnt == 2'd0;
  assign full     = cnt == 2'd2;
  assign rd       = slots[0];
  assign cnt_left = cnt - {1'b0, pop};

  // Occupancy count.
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= 2'd0;
    end else begin
      cnt <= cnt_left + {1'b0, push};
    end
  end

  // Shift out the head on a pop and write behind the remaining entries.
  always_ff @(posedge clk) begin
    if (push && !cnt_left[0]) begin
      slots[0] <= wr;
    end else if (pop) begin
      slots[0] <= slots[1];
    end
    if (push && cnt_left[0]) begin
      slots[1] <= wr;
    end
  end

endmodule

// File: rtl/sod_back.sv
// Back end: divides for the mean, tracks the noise floor and decides events.
`include "sound_onset_detector_defines.svh"

module sod_back (
  input  logic             clk,
  input  logic             rst,
  input  sod_pkg::cfg_t    cfg,
  input  logic             cq_empty,
  input  sod_pkg::chunk_t  cq_rd,
  output logic             cq_pop,
  input  logic             pop,
  output logic             empty,
  output sod_pkg::result_t result
);
  import sod_pkg::*;

  back_state_t state;
  back_state_t state_next;

  // Chunk under work and divider registers.
  chunk_t             rec;
  logic [COUNT_W-1:0] rem;
  logic [TOTAL_W-1:0] quo;
  logic [STEP_W-1:0]  step;

  // Detector state.
  logic [15:0] floor_avg;
  logic        floor_seeded;
  logic [15:0] chunk_tally;
  logic [15:0] holdoff_left;

  // Per-chunk working values.
  logic [15:0] mean;
  logic [31:0] mean_prod;
  logic [31:0] mean_thr;
  logic [31:0] peak_prod;
  logic [31:0] peak_thr;

  // Result queue.
  result_t    oq [2];
  logic [1:0] oq_cnt;
  logic [1:0] oq_left;
  logic       oq_full;
  logic       oq_push;
  logic       oq_pop;
  result_t    oq_wr;

  logic               start;
  logic [COUNT_W:0]   trial;
  logic               qbit;
  logic [COUNT_W-1:0] rem_next;
  logic [15:0]        div_mean;
  logic signed [17:0] diff;
  logic signed [17:0] floor_sum;
  logic [15:0]        floor_ema;
  logic [15:0]        floor_eff;
  logic               fire;

  assign oq_full = oq_cnt == 2'd2;
  assign empty   = oq_cnt == 2'd0;
  assign oq_pop  = pop && !empty;
  assign result  = oq[0];
  assign oq_left = oq_cnt - {1'b0, oq_pop};
  assign start   = !cq_empty && !oq_full;

  // Next state of the chunk sequencer.
  always_comb begin
    state_next = state;
    unique case (state)
      BK_IDLE:   if (start) state_next = BK_DIV;
      BK_DIV:    if (step == STEP_W'(TOTAL_W - 1)) state_next = BK_UPDATE;
      BK_UPDATE: state_next = BK_MULT;
      BK_MULT:   state_next = BK_DECIDE;
      BK_DECIDE: state_next = BK_IDLE;
      default:   state_next = BK_IDLE;
    endcase
  end

  // Sequencer outputs.
  always_comb begin
    cq_pop  = 1'b0;
    oq_push = 1'b0;
    unique case (state)
      BK_IDLE:   cq_pop  = start;
      BK_DECIDE: oq_push = 1'b1;
      default: begin
        cq_pop  = 1'b0;
        oq_push = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= BK_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // One restoring division step per cycle.
  always_comb begin
    trial    = {rem, quo[TOTAL_W-1]};
    qbit     = trial >= {1'b0, rec.count};
    rem_next = qbit ? COUNT_W'(trial - {1'b0, rec.count}) : trial[COUNT_W-1:0];
    div_mean = quo[15:0];
  end

  // Moving average step; the arithmetic shift rounds toward minus infinity.
  always_comb begin
    diff      = $signed({2'b00, div_mean}) - $signed({2'b00, floor_avg});
    floor_sum = $signed({2'b00, floor_avg}) + (diff >>> cfg.floor_shift);
    floor_ema = floor_sum[15:0];
    floor_eff = (floor_avg == 16'd0) ? 16'd1 : floor_avg;
  end

  // Event decision on the registered products.
  always_comb begin
    fire = chunk_tally >= cfg.settle_chunks && holdoff_left == 16'd0 &&
           rec.peak >= cfg.min_peak && mean >= cfg.min_mean &&
           mean_prod >= mean_thr && peak_prod >= peak_thr;
    oq_wr.event_res   = fire;
    oq_wr.peak_level  = rec.peak;
    oq_wr.mean_level  = mean;
    oq_wr.floor_level = floor_avg;
    oq_wr.overlong    = rec.overlong;
  end

  // Working registers of the chunk under work.
  always_ff @(posedge clk) begin
    unique case (state)
      BK_IDLE: begin
        if (start) begin
          rec  <= cq_rd;
          rem  <= '0;
          quo  <= cq_rd.total;
          step <= '0;
        end
      end
      BK_DIV: begin
        rem  <= rem_next;
        quo  <= {quo[TOTAL_W-2:0], qbit};
        step <= step + STEP_W'(1);
      end
      BK_UPDATE: mean <= div_mean;
      BK_MULT: begin
        mean_prod <= {16'd0, mean} * {16'd0, RATIO_SCALE};
        mean_thr  <= {16'd0, floor_eff} * {16'd0, cfg.mean_ratio_x100};
        peak_prod <= {16'd0, rec.peak} * {16'd0, RATIO_SCALE};
        peak_thr  <= {16'd0, floor_eff} * {16'd0, cfg.peak_ratio_x100};
      end
      default: begin
      end
    endcase
  end

  // Floor, chunk count and holdoff.
  always_ff @(posedge clk) begin
    if (rst) begin
      floor_avg    <= '0;
      floor_seeded <= 1'b0;
      chunk_tally  <= '0;
      holdoff_left <= '0;
    end else if (state == BK_UPDATE) begin
      if (chunk_tally != 16'hFFFF) begin
        chunk_tally <= chunk_tally + 16'd1;
      end
      if (!floor_seeded) begin
        floor_avg    <= div_mean;
        floor_seeded <= 1'b1;
      end else if (holdoff_left == 16'd0) begin
        floor_avg <= floor_ema;
      end
      if (holdoff_left != 16'd0) begin
        holdoff_left <= holdoff_left - 16'd1;
      end
    end else if (state == BK_DECIDE && fire) begin
      holdoff_left <= cfg.holdoff_chunks;
    end
  end

  // Result queue occupancy and storage.
  always_ff @(posedge clk) begin
    if (rst) begin
      oq_cnt <= 2'd0;
    end else begin
      oq_cnt <= oq_left + {1'b0, oq_push};
    end
  end

  always_ff @(posedge clk) begin
    if (oq_push && !oq_left[0]) begin
      oq[0] <= oq_wr;
    end else if (oq_pop) begin
      oq[0] <= oq[1];
    end
    if (oq_push && oq_left[0]) begin
      oq[1] <= oq_wr;
    end
  end

  `SOD_ASSERT_IMPL(a_oq_no_overflow, oq_push, (oq_cnt != 2'd2) || oq_pop)
  `SOD_ASSERT_IMPL(a_start_has_room, cq_pop, !oq_full && !cq_empty)
  `SOD_ASSERT_NEXT(a_holdoff_load, state == BK_DECIDE && fire, holdoff_left == $past(cfg.holdoff_chunks))
  `SOD_ASSERT_NEXT(a_tally_monotone, 1'b1, chunk_tally >= $past(chunk_tally))

endmodule

// File: rtl/sound_onset_detector.sv
// Sound onset detector: samples are taken one per clock while push is high and full is
// low; the front accumulates each chunk and hands it at its last sample to a two-entry
// queue. The back end works on one chunk at a time through its one-bit-per-cycle mean
// divider and its update, multiply and decide states, so a stream of short chunks
// raises full once the queue holds two chunks. One result per chunk leaves
// through a two-entry result queue (empty/pop). Registers are written through cfg_we,
// cfg_index and cfg_data and should change only while the block is idle.
module sound_onset_detector (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  sod_pkg::item_t   item,
  output logic             full,
  output logic             empty,
  input  logic             pop,
  output sod_pkg::result_t result,
  input  logic             cfg_we,
  input  logic [2:0]       cfg_index,
  input  logic [15:0]      cfg_data
);
  import sod_pkg::*;

  cfg_t   cfg;
  logic   cq_push;
  logic   cq_pop;
  logic   cq_empty;
  logic   cq_full;
  chunk_t cq_wr;
  chunk_t cq_rd;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.min_peak        <= MIN_PEAK_RST;
      cfg.min_mean        <= MIN_MEAN_RST;
      cfg.mean_ratio_x100 <= MEAN_RATIO_RST;
      cfg.peak_ratio_x100 <= PEAK_RATIO_RST;
      cfg.floor_shift     <= FLOOR_SHIFT_RST;
      cfg.holdoff_chunks  <= HOLDOFF_RST;
      cfg.settle_chunks   <= SETTLE_RST;
    end else if (cfg_we) begin
      unique case (reg_idx_t'(cfg_index))
        REG_MIN_PEAK:    cfg.min_peak        <= cfg_data;
        REG_MIN_MEAN:    cfg.min_mean        <= cfg_data;
        REG_MEAN_RATIO:  cfg.mean_ratio_x100 <= cfg_data;
        REG_PEAK_RATIO:  cfg.peak_ratio_x100 <= cfg_data;
        REG_FLOOR_SHIFT: cfg.floor_shift     <= cfg_data[3:0];
        REG_HOLDOFF:     cfg.holdoff_chunks  <= cfg_data;
        REG_SETTLE:      cfg.settle_chunks   <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // Sample accumulation.
  sod_front u_front (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .item    (item),
    .cq_full (cq_full),
    .full    (full),
    .cq_push (cq_push),
    .cq_wr   (cq_wr)
  );

  // Chunk queue between front and back.
  sod_chunk_q u_chunk_q (
    .clk   (clk),
    .rst   (rst),
    .push  (cq_push),
    .wr    (cq_wr),
    .pop   (cq_pop),
    .rd    (cq_rd),
    .empty (cq_empty),
    .full  (cq_full)
  );

  // Chunk evaluation and result queue.
  sod_back u_back (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .cq_empty (cq_empty),
    .cq_rd    (cq_rd),
    .cq_pop   (cq_pop),
    .pop      (pop),
    .empty    (empty),
    .result   (result)
  );

endmodule
